// ===== rtl/core/wpr_pkg.sv =====
package wpr_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int MAX_TERMS     = 7;
   localparam int DATA_W        = 32;
   localparam int TERM_W        = 3;
   localparam int SIGMA_W       = 31;
   localparam int DIV_W         = DATA_W + FRACTION_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_W);
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [1:0] OP_RESIDUAL = 2'd0;
   localparam logic [1:0] OP_JACOBIAN = 2'd1;
   localparam logic [1:0] OP_BOTH     = 2'd2;
   localparam logic [1:0] OP_BOTH_ALT = 2'd3;

   localparam logic KIND_RESIDUAL = 1'b0;
   localparam logic KIND_JACOBIAN = 1'b1;

   localparam logic [2:0] REG_TERM_COUNT = 3'd0;
   localparam logic [2:0] REG_COEF_0     = 3'd1;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

   localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'sd1 <<< FRACTION_BITS);

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [DATA_W-1:0] sample_position;
      logic signed [DATA_W-1:0] measured_value;
      logic [SIGMA_W-1:0]       uncertainty;
      logic                     last_point;
   } req_word_type;

   typedef struct packed {
      logic                     result_kind;
      logic [TERM_W-1:0]        term_index;
      logic signed [DATA_W-1:0] value;
      logic                     saturated;
      logic                     sigma_zero;
      logic                     last_of_item;
      logic                     last_of_set;
   } rsp_word_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] numer;
      logic [SIGMA_W-1:0]       denom;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic                     ovf;
      logic signed [DATA_W-1:0] quot;
   } div_sts_type;

   function automatic logic signed [63:0] sext64(input logic signed [DATA_W-1:0] v);
      sext64 = {{(64-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic sat_type sat64(input logic signed [63:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.ovf   = 1'b1;
         r.value = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r.ovf   = 1'b1;
         r.value = SAT_LO[DATA_W-1:0];
      end else begin
         r.ovf   = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/wpr_div.sv =====
module wpr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wpr_pkg::div_req_type div_req,
   output wpr_pkg::div_sts_type div_sts
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [wpr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [wpr_pkg::SIGMA_W-1:0]   rem_ff, rem_in;
   logic [wpr_pkg::SIGMA_W-1:0]   den_ff, den_in;
   logic [wpr_pkg::DIV_W-1:0]     dvd_ff, dvd_in;

   logic [wpr_pkg::DATA_W-1:0]    abs_num;
   logic [wpr_pkg::SIGMA_W:0]     shifted;
   logic [wpr_pkg::SIGMA_W+1:0]   diff;
   logic                          pos_ovf;
   logic                          neg_ovf;
   logic [wpr_pkg::DATA_W-1:0]    neg_mag;

   assign abs_num = div_req.numer[wpr_pkg::DATA_W-1] ? (~div_req.numer + 1'b1)
                                                     : div_req.numer;
   assign shifted = {rem_ff, dvd_ff[wpr_pkg::DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.numer[wpr_pkg::DATA_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.denom;
         dvd_in  = {abs_num, {wpr_pkg::FRACTION_BITS{1'b0}}};
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         if (!diff[wpr_pkg::SIGMA_W+1]) begin
            rem_in = diff[wpr_pkg::SIGMA_W-1:0];
            dvd_in = {dvd_ff[wpr_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[wpr_pkg::SIGMA_W-1:0];
            dvd_in = {dvd_ff[wpr_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == wpr_pkg::DIV_CNT_W'(wpr_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
   end

   // quotient magnitude sits in dvd_ff once done
   assign pos_ovf = |dvd_ff[wpr_pkg::DIV_W-1:wpr_pkg::DATA_W-1];
   assign neg_ovf = (|dvd_ff[wpr_pkg::DIV_W-1:wpr_pkg::DATA_W])
                  || (dvd_ff[wpr_pkg::DATA_W-1] && (|dvd_ff[wpr_pkg::DATA_W-2:0]));
   assign neg_mag = ~dvd_ff[wpr_pkg::DATA_W-1:0] + 1'b1;

   always_comb begin
      div_sts.busy = busy_ff;
      div_sts.done = done_ff;
      if (neg_ff) begin
         div_sts.ovf  = neg_ovf;
         div_sts.quot = neg_ovf ? wpr_pkg::SAT_LO[wpr_pkg::DATA_W-1:0] : neg_mag;
      end else begin
         div_sts.ovf  = pos_ovf;
         div_sts.quot = pos_ovf ? wpr_pkg::SAT_HI[wpr_pkg::DATA_W-1:0]
                                : dvd_ff[wpr_pkg::DATA_W-1:0];
      end
   end

endmodule

// ===== rtl/core/weighted_polynomial_residual.sv =====
// channel   direction  handshake            word
// req       in         req_valid/req_stall  wpr_pkg::req_word_type
// rsp       out        rsp_valid/rsp_stall  wpr_pkg::rsp_word_type
// csr       in/out     psel/penable/pready  32-bit registers at 4*index
//
// a jacobian row alone skips the weighted sum
// the bit-serial divider makes one pass per result word when sigma is nonzero
// powers and the weighted sum share one 32x32 multiplier, a multiply then an update phase per term
// reset clears the sequencer, term_count to 1 and coefficients to 0
// req_stall is high from acceptance until the last word is in the output register
// rsp words wait in the output register while rsp_stall is high
module weighted_polynomial_residual (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wpr_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wpr_pkg::rsp_word_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wpr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [wpr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [wpr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POW  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_SUBY = 3'd3;
   localparam logic [2:0] ST_JAC  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   // config registers
   logic [wpr_pkg::TERM_W-1:0]        term_count_ff, term_count_in;
   logic signed [wpr_pkg::DATA_W-1:0] coef_ff [wpr_pkg::MAX_TERMS];
   logic signed [wpr_pkg::DATA_W-1:0] coef_in [wpr_pkg::MAX_TERMS];

   // sequencer
   logic [2:0]                        state_ff, state_in;
   logic                              phase_ff, phase_in;
   logic [wpr_pkg::TERM_W-1:0]        k_ff, k_in;
   logic [wpr_pkg::TERM_W-1:0]        nterms_ff, nterms_in;
   logic [1:0]                        op_ff, op_in;
   logic signed [wpr_pkg::DATA_W-1:0] t_ff, t_in;
   logic signed [wpr_pkg::DATA_W-1:0] y_ff, y_in;
   logic [wpr_pkg::SIGMA_W-1:0]       sigma_ff, sigma_in;
   logic                              last_ff, last_in;
   logic signed [wpr_pkg::DATA_W-1:0] pw_ff [wpr_pkg::MAX_TERMS];
   logic signed [wpr_pkg::DATA_W-1:0] pw_in [wpr_pkg::MAX_TERMS];
   logic [wpr_pkg::MAX_TERMS-1:0]     pws_ff, pws_in;
   logic signed [63:0]                prod_ff, prod_in;
   logic signed [wpr_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                              flag_ff, flag_in;
   logic                              kind_ff, kind_in;
   logic signed [wpr_pkg::DATA_W-1:0] val_ff, val_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   wpr_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [wpr_pkg::TERM_W-1:0]        pw_idx;
   logic signed [wpr_pkg::DATA_W-1:0] pw_rd;
   logic                              pws_rd;
   logic signed [wpr_pkg::DATA_W-1:0] mul_a;
   logic signed [wpr_pkg::DATA_W-1:0] mul_b;
   logic signed [63:0]                mul_p;
   wpr_pkg::sat_type                  prod_sat;
   wpr_pkg::sat_type                  sum_sat;
   wpr_pkg::sat_type                  suby_sat;
   logic                              sigma_zero;
   logic                              last_item;
   logic                              csr_write;
   logic [2:0]                        csr_idx;
   logic [wpr_pkg::TERM_W-1:0]        coef_sel;
   logic [wpr_pkg::TERM_W-1:0]        req_terms;
   wpr_pkg::div_req_type              div_req;
   wpr_pkg::div_sts_type              div_sts;

   wpr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = paddr[wpr_pkg::CSR_ADDR_W-1:2];
   assign coef_sel  = csr_idx - wpr_pkg::REG_COEF_0;

   always_comb begin
      if (csr_idx == wpr_pkg::REG_TERM_COUNT) begin
         prdata = {{(wpr_pkg::CSR_DATA_W-wpr_pkg::TERM_W){1'b0}}, term_count_ff};
      end else begin
         prdata = coef_ff[coef_sel];
      end
   end

   always_comb begin
      term_count_in = term_count_ff;
      for (int i = 0; i < wpr_pkg::MAX_TERMS; i++) begin
         coef_in[i] = coef_ff[i];
      end
      if (csr_write) begin
         if (csr_idx == wpr_pkg::REG_TERM_COUNT) begin
            term_count_in = pwdata[wpr_pkg::TERM_W-1:0];
         end else begin
            coef_in[coef_sel] = pwdata;
         end
      end
   end

   // shared multiplier datapath
   assign pw_idx     = (state_ff == ST_POW) ? (k_ff - 1'b1) : k_ff;
   assign pw_rd      = pw_ff[pw_idx];
   assign pws_rd     = pws_ff[pw_idx];
   assign mul_a      = (state_ff == ST_POW) ? t_ff : coef_ff[k_ff];
   assign mul_b      = pw_rd;
   assign mul_p      = mul_a * mul_b;
   assign prod_sat   = wpr_pkg::sat64(prod_ff >>> wpr_pkg::FRACTION_BITS);
   assign sum_sat    = wpr_pkg::sat64(wpr_pkg::sext64(acc_ff)
                                      + wpr_pkg::sext64(prod_sat.value));
   assign suby_sat   = wpr_pkg::sat64(wpr_pkg::sext64(acc_ff) - wpr_pkg::sext64(y_ff));
   assign sigma_zero = (sigma_ff == '0);
   assign last_item  = (kind_ff == wpr_pkg::KIND_RESIDUAL) ? (op_ff == wpr_pkg::OP_RESIDUAL)
                                                           : (k_ff == nterms_ff - 1'b1);

   always_comb begin
      if (term_count_ff == '0) begin
         req_terms = wpr_pkg::TERM_W'(1);
      end else if (term_count_ff > wpr_pkg::TERM_W'(wpr_pkg::MAX_TERMS)) begin
         req_terms = wpr_pkg::TERM_W'(wpr_pkg::MAX_TERMS);
      end else begin
         req_terms = term_count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      nterms_in    = nterms_ff;
      op_in        = op_ff;
      t_in         = t_ff;
      y_in         = y_ff;
      sigma_in     = sigma_ff;
      last_in      = last_ff;
      for (int i = 0; i < wpr_pkg::MAX_TERMS; i++) begin
         pw_in[i] = pw_ff[i];
      end
      pws_in       = pws_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      flag_in      = flag_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      div_req.start = 1'b0;
      div_req.numer = acc_ff;
      div_req.denom = sigma_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = (req_data.operation == wpr_pkg::OP_BOTH_ALT) ? wpr_pkg::OP_BOTH
                                                                        : req_data.operation;
               t_in      = req_data.sample_position;
               y_in      = req_data.measured_value;
               sigma_in  = req_data.uncertainty;
               last_in   = req_data.last_point;
               nterms_in = req_terms;
               pw_in[0]  = wpr_pkg::FX_ONE;
               pws_in[0] = 1'b0;
               acc_in    = '0;
               flag_in   = 1'b0;
               phase_in  = 1'b0;
               if (req_terms == wpr_pkg::TERM_W'(1)) begin
                  k_in     = '0;
                  state_in = (op_in == wpr_pkg::OP_JACOBIAN) ? ST_JAC : ST_SUM;
               end else begin
                  k_in     = wpr_pkg::TERM_W'(1);
                  state_in = ST_POW;
               end
            end
         end
         ST_POW: begin
            if (!phase_ff) begin
               prod_in  = mul_p;
               phase_in = 1'b1;
            end else begin
               pw_in[k_ff]  = prod_sat.value;
               pws_in[k_ff] = pws_rd || prod_sat.ovf;
               phase_in     = 1'b0;
               if (k_ff == nterms_ff - 1'b1) begin
                  k_in     = '0;
                  state_in = (op_ff == wpr_pkg::OP_JACOBIAN) ? ST_JAC : ST_SUM;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (!phase_ff) begin
               prod_in  = mul_p;
               phase_in = 1'b1;
            end else begin
               flag_in  = flag_ff || prod_sat.ovf || pws_rd || sum_sat.ovf;
               acc_in   = sum_sat.value;
               phase_in = 1'b0;
               if (k_ff == nterms_ff - 1'b1) begin
                  k_in     = '0;
                  state_in = ST_SUBY;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_SUBY: begin
            acc_in  = suby_sat.value;
            flag_in = flag_ff || suby_sat.ovf;
            kind_in = wpr_pkg::KIND_RESIDUAL;
            if (sigma_zero) begin
               val_in   = '0;
               state_in = ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               div_req.numer = suby_sat.value;
               state_in      = ST_DIV;
            end
         end
         ST_JAC: begin
            kind_in = wpr_pkg::KIND_JACOBIAN;
            flag_in = pws_rd;
            if (sigma_zero) begin
               val_in   = '0;
               state_in = ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               div_req.numer = pw_rd;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               val_in   = div_sts.quot;
               flag_in  = flag_ff || div_sts.ovf;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.result_kind  = kind_ff;
               rsp_word_in.term_index   = (kind_ff == wpr_pkg::KIND_RESIDUAL) ? '0 : k_ff;
               rsp_word_in.value        = val_ff;
               rsp_word_in.saturated    = flag_ff;
               rsp_word_in.sigma_zero   = sigma_zero;
               rsp_word_in.last_of_item = last_item;
               rsp_word_in.last_of_set  = last_item && last_ff;
               if (last_item) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == wpr_pkg::KIND_RESIDUAL) begin
                  k_in     = '0;
                  state_in = ST_JAC;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_JAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         term_count_ff <= wpr_pkg::TERM_W'(1);
         for (int i = 0; i < wpr_pkg::MAX_TERMS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         term_count_ff <= term_count_in;
         for (int i = 0; i < wpr_pkg::MAX_TERMS; i++) begin
            coef_ff[i] <= coef_in[i];
         end
      end
      k_ff        <= k_in;
      nterms_ff   <= nterms_in;
      op_ff       <= op_in;
      t_ff        <= t_in;
      y_ff        <= y_in;
      sigma_ff    <= sigma_in;
      last_ff     <= last_in;
      for (int i = 0; i < wpr_pkg::MAX_TERMS; i++) begin
         pw_ff[i] <= pw_in[i];
      end
      pws_ff      <= pws_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      flag_ff     <= flag_in;
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer idle after accepting a word");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_sigma_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.sigma_zero) |-> (rsp_data.value == '0))
      else $error("zero sigma word with nonzero value");

   a_residual_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == wpr_pkg::KIND_RESIDUAL))
      |-> (rsp_data.term_index == '0))
      else $error("residual word with nonzero term index");

   a_set_implies_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_set) |-> rsp_data.last_of_item)
      else $error("last of set without last of item");
`endif

endmodule

// ===== test/tb_weighted_polynomial_residual.sv =====
module tb_weighted_polynomial_residual;

   localparam longint SPAN_HI = 64'sd2147483647;
   localparam longint SPAN_LO = -SPAN_HI - 1;
   localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] FX_MIN = 32'h8000_0000;
   localparam logic [30:0] SIGMA_MAX = 31'h7FFF_FFFF;
   localparam logic [30:0] SIGMA_ONE = 31'h0001_0000;
   localparam int SETTLE_CYCLES = 16;
   localparam int END_CYCLES = 450;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_POINTS = 38;

   typedef struct packed {
      logic                  is_write;
      logic [2:0]            reg_index;
      logic [31:0]           reg_value;
      wpr_pkg::req_word_type point;
      logic                  typed;
      wpr_pkg::rsp_word_type known;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   wpr_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wpr_pkg::rsp_word_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [wpr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [wpr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [wpr_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   logic [2:0] terms_cfg = 3'd1;
   logic signed [31:0] coef_cfg [wpr_pkg::MAX_TERMS] = '{default: '0};
   wpr_pkg::rsp_word_type words_due [$];
   plan_row_type plan [$];
   int gap_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   weighted_polynomial_residual DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(input longint v, inout bit ovf);
      if (v > SPAN_HI) begin
         ovf = 1'b1;
         return SPAN_HI;
      end
      if (v < SPAN_LO) begin
         ovf = 1'b1;
         return SPAN_LO;
      end
      return v;
   endfunction

   function automatic longint fx_product(input longint a, input longint b, inout bit ovf);
      longint p;
      p = a * b;
      return clamp32(p >>> wpr_pkg::FRACTION_BITS, ovf);
   endfunction

   function automatic longint fx_quotient(input longint num, input longint den, inout bit ovf);
      longint n;
      n = num * (longint'(1) <<< wpr_pkg::FRACTION_BITS);
      return clamp32(n / den, ovf);
   endfunction

   function automatic void evaluate_point(input wpr_pkg::req_word_type p);
      longint pw [wpr_pkg::MAX_TERMS];
      bit pw_ovf [wpr_pkg::MAX_TERMS];
      bit chain, f, sz;
      longint t, sigma, acc, term, v;
      int n, k;
      logic [1:0] op;
      wpr_pkg::rsp_word_type w;
      wpr_pkg::rsp_word_type words [$];
      n = (terms_cfg == 3'd0) ? 1 : int'(terms_cfg);
      if (n > wpr_pkg::MAX_TERMS) n = wpr_pkg::MAX_TERMS;
      op = (p.operation == wpr_pkg::OP_BOTH_ALT) ? wpr_pkg::OP_BOTH : p.operation;
      t = longint'($signed(p.sample_position));
      sigma = longint'(p.uncertainty);
      sz = (sigma == 0);
      chain = 1'b0;
      pw[0] = longint'(wpr_pkg::FX_ONE);
      pw_ovf[0] = 1'b0;
      for (k = 1; k < n; k++) begin
         pw[k] = fx_product(pw[k-1], t, chain);
         pw_ovf[k] = chain;
      end
      if (op != wpr_pkg::OP_JACOBIAN) begin
         f = 1'b0;
         acc = 0;
         for (k = 0; k < n; k++) begin
            term = fx_product(longint'(coef_cfg[k]), pw[k], f);
            if (pw_ovf[k]) f = 1'b1;
            acc = clamp32(acc + term, f);
         end
         acc = clamp32(acc - longint'($signed(p.measured_value)), f);
         v = 0;
         if (!sz) v = fx_quotient(acc, sigma, f);
         w = '0;
         w.result_kind = wpr_pkg::KIND_RESIDUAL;
         w.value = v[31:0];
         w.saturated = f;
         w.sigma_zero = sz;
         words.push_back(w);
      end
      if (op != wpr_pkg::OP_RESIDUAL) begin
         for (k = 0; k < n; k++) begin
            f = pw_ovf[k];
            v = 0;
            if (!sz) v = fx_quotient(pw[k], sigma, f);
            w = '0;
            w.result_kind = wpr_pkg::KIND_JACOBIAN;
            w.term_index = k[2:0];
            w.value = v[31:0];
            w.saturated = f;
            w.sigma_zero = sz;
            words.push_back(w);
         end
      end
      words[words.size()-1].last_of_item = 1'b1;
      words[words.size()-1].last_of_set = p.last_point;
      foreach (words[i]) words_due.push_back(words[i]);
   endfunction

   function automatic logic [31:0] random_fixed();
      logic [31:0] r;
      case ($urandom_range(0, 5))
         0, 1: r = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         2: r = 32'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
         3: begin
            case ($urandom_range(0, 3))
               0: r = FX_MAX;
               1: r = FX_MIN;
               2: r = wpr_pkg::FX_ONE;
               default: r = -wpr_pkg::FX_ONE;
            endcase
         end
         default: r = $urandom;
      endcase
      return r;
   endfunction

   function automatic wpr_pkg::req_word_type random_point();
      wpr_pkg::req_word_type p;
      p.operation = 2'($urandom_range(0, 3));
      p.sample_position = random_fixed();
      p.measured_value = random_fixed();
      case ($urandom_range(0, 9))
         0: p.uncertainty = '0;
         1: p.uncertainty = 31'd1;
         2: p.uncertainty = SIGMA_MAX;
         3, 4: p.uncertainty = 31'($urandom);
         default: p.uncertainty = 31'($urandom_range(32'h1000, 32'h8_0000));
      endcase
      p.last_point = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic plan_write(input logic [2:0] index, input logic [31:0] data);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = index;
      r.reg_value = data;
      plan.push_back(r);
   endtask

   task automatic plan_point(input logic [1:0] op, input logic [31:0] t, y,
                             input logic [30:0] s, input logic last);
      plan_row_type r;
      r = '0;
      r.point = '{op, t, y, s, last};
      plan.push_back(r);
   endtask

   task automatic plan_known(input logic [1:0] op, input logic [31:0] t, y,
                             input logic [30:0] s, input logic last,
                             input logic [31:0] v, input logic sat, sz);
      plan_row_type r;
      r = '0;
      r.point = '{op, t, y, s, last};
      r.typed = 1'b1;
      r.known.result_kind = (op == wpr_pkg::OP_JACOBIAN) ? wpr_pkg::KIND_JACOBIAN
                                                         : wpr_pkg::KIND_RESIDUAL;
      r.known.value = v;
      r.known.saturated = sat;
      r.known.sigma_zero = sz;
      r.known.last_of_item = 1'b1;
      r.known.last_of_set = last;
      plan.push_back(r);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index == wpr_pkg::REG_TERM_COUNT) terms_cfg = data[2:0];
      else coef_cfg[index - wpr_pkg::REG_COEF_0] = data;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_point(input wpr_pkg::req_word_type p, input logic typed,
                             input wpr_pkg::rsp_word_type known);
      req_data <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (typed) words_due.push_back(known);
      else evaluate_point(p);
      if ($urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 100));
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin : check_words
      wpr_pkg::rsp_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            note_mismatch("word with nothing due", rsp_data.value, '0);
         end else begin
            due = words_due.pop_front();
            if (rsp_data.result_kind !== due.result_kind)
               note_mismatch("result_kind", 32'(rsp_data.result_kind), 32'(due.result_kind));
            if (rsp_data.term_index !== due.term_index)
               note_mismatch("term_index", 32'(rsp_data.term_index), 32'(due.term_index));
            if (rsp_data.value !== due.value)
               note_mismatch("value", rsp_data.value, due.value);
            if (rsp_data.saturated !== due.saturated)
               note_mismatch("saturated", 32'(rsp_data.saturated), 32'(due.saturated));
            if (rsp_data.sigma_zero !== due.sigma_zero)
               note_mismatch("sigma_zero", 32'(rsp_data.sigma_zero), 32'(due.sigma_zero));
            if (rsp_data.last_of_item !== due.last_of_item)
               note_mismatch("last_of_item", 32'(rsp_data.last_of_item),
                             32'(due.last_of_item));
            if (rsp_data.last_of_set !== due.last_of_set)
               note_mismatch("last_of_set", 32'(rsp_data.last_of_set), 32'(due.last_of_set));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_weighted_polynomial_residual: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int i, phase, k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: one term, zero coefficients
      plan_known(wpr_pkg::OP_RESIDUAL, '0, '0, SIGMA_ONE, 1'b0, '0, 1'b0, 1'b0);
      plan_known(wpr_pkg::OP_RESIDUAL, FX_MAX, wpr_pkg::FX_ONE, SIGMA_ONE, 1'b0,
                 -wpr_pkg::FX_ONE, 1'b0, 1'b0);
      plan_known(wpr_pkg::OP_RESIDUAL, FX_MIN, FX_MIN, SIGMA_ONE, 1'b0, FX_MAX, 1'b1, 1'b0);
      plan_known(wpr_pkg::OP_RESIDUAL, '0, wpr_pkg::FX_ONE, '0, 1'b0, '0, 1'b0, 1'b1);
      plan_known(wpr_pkg::OP_JACOBIAN, FX_MIN, FX_MAX, SIGMA_ONE, 1'b0, wpr_pkg::FX_ONE,
                 1'b0, 1'b0);
      plan_known(wpr_pkg::OP_JACOBIAN, wpr_pkg::FX_ONE, '0, 31'd1, 1'b0, FX_MAX, 1'b1, 1'b0);
      plan_known(wpr_pkg::OP_JACOBIAN, wpr_pkg::FX_ONE, '0, '0, 1'b0, '0, 1'b0, 1'b1);
      plan_known(wpr_pkg::OP_RESIDUAL, '0, FX_MAX, SIGMA_MAX, 1'b1, -wpr_pkg::FX_ONE,
                 1'b0, 1'b0);
      // zero term count behaves as one term
      plan_write(wpr_pkg::REG_TERM_COUNT, 32'd0);
      plan_point(wpr_pkg::OP_BOTH, 32'h3_0000, wpr_pkg::FX_ONE, 31'h8000, 1'b1);
      plan_write(wpr_pkg::REG_TERM_COUNT, wpr_pkg::MAX_TERMS);
      plan_write(wpr_pkg::REG_COEF_0, wpr_pkg::FX_ONE);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd1, -wpr_pkg::FX_ONE);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd2, FX_MAX);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd3, FX_MIN);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd4, 32'h0000_8000);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd5, 32'hFFFF_8000);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd6, 32'h0000_0001);
      plan_point(wpr_pkg::OP_BOTH, 32'h2_0000, '0, SIGMA_ONE, 1'b0);
      plan_point(wpr_pkg::OP_BOTH_ALT, FX_MAX, FX_MIN, SIGMA_ONE, 1'b0);
      plan_point(wpr_pkg::OP_JACOBIAN, FX_MIN, '0, SIGMA_MAX, 1'b0);
      plan_point(wpr_pkg::OP_BOTH, 32'hFFFF_8000, wpr_pkg::FX_ONE, '0, 1'b0);
      plan_point(wpr_pkg::OP_RESIDUAL, 32'h1_8000, FX_MAX, SIGMA_MAX, 1'b1);
      plan_point(wpr_pkg::OP_BOTH, 32'h2_0000, -wpr_pkg::FX_ONE, 31'd1, 1'b0);
      plan_write(wpr_pkg::REG_TERM_COUNT, 32'd4);
      plan_write(wpr_pkg::REG_COEF_0, 32'hFFFE_0000);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd1, 32'h0003_0000);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd2, 32'hFFFF_0000);
      plan_write(wpr_pkg::REG_COEF_0 + 3'd3, 32'h0000_4000);
      plan_point(wpr_pkg::OP_BOTH, -wpr_pkg::FX_ONE, FX_MIN, SIGMA_ONE, 1'b0);
      plan_point(wpr_pkg::OP_BOTH_ALT, '0, 32'h1234_5678, SIGMA_MAX, 1'b1);
      plan_point(wpr_pkg::OP_RESIDUAL, 32'h0000_8000, 32'hEDCB_A987, 31'h100, 1'b1);

      foreach (plan[r]) begin
         if (plan[r].is_write) begin
            drain_points();
            write_register(plan[r].reg_index, plan[r].reg_value);
         end else begin
            send_point(plan[r].point, plan[r].typed, plan[r].known);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         drain_points();
         case (phase)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 50; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 50; end
            default: begin gap_pct = 25; stall_pct = 25; end
         endcase
         case (phase)
            0: write_register(wpr_pkg::REG_TERM_COUNT, wpr_pkg::MAX_TERMS);
            1: write_register(wpr_pkg::REG_TERM_COUNT, 32'd1);
            default: write_register(wpr_pkg::REG_TERM_COUNT,
                                    $urandom_range(1, wpr_pkg::MAX_TERMS));
         endcase
         for (k = 0; k < wpr_pkg::MAX_TERMS; k++)
            write_register(wpr_pkg::REG_COEF_0 + 3'(k), random_fixed());
         for (i = 0; i < PHASE_POINTS; i++) begin
            // halfway through, hold the next word until every result word is out
            if (i == PHASE_POINTS / 2) drain_points();
            send_point(random_point(), 1'b0, '0);
         end
      end

      drain_points();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_weighted_polynomial_residual: done, clean");
      else
         $display("tb_weighted_polynomial_residual: done, errors");
      $finish;
   end

endmodule
